>>> hdl/fcbb_pkg.sv
package fcbb_pkg;

    // pixel and group geometry
    localparam int PIX_W        = 32;
    localparam int GROUP_PIXELS = 4;

    // side limit and register defaults
    localparam int DEF_MAX_SIDE     = 4096;
    localparam int MIN_FRAME_WIDTH  = 4;
    localparam int MIN_FRAME_HEIGHT = 1;
    localparam int RST_FRAME_WIDTH  = 1920;
    localparam int RST_FRAME_HEIGHT = 1080;

    // port widths of the configuration data and the result
    localparam int CFG_DW  = 13;
    localparam int POS_OW  = 12;
    localparam int SIZE_OW = 13;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [GROUP_PIXELS-1:0] t_group;

    function automatic logic [31:0] clamp_side(
        input logic [31:0] v,
        input logic [31:0] lo,
        input logic [31:0] hi
    );
        logic [31:0] r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

    function automatic t_pix group_sum(input t_group g);
        t_pix s01;
        t_pix s23;
        s01 = g[0] + g[1];
        s23 = g[2] + g[3];
        return s01 + s23;
    endfunction

endpackage

>>> hdl/fcbb_front.sv
module fcbb_front #(
    parameter int MAX_SIDE = fcbb_pkg::DEF_MAX_SIDE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  fcbb_pkg::t_group                     i_old_group,
    input  fcbb_pkg::t_group                     i_new_group,
    input  logic                                 i_q_full,
    input  logic [$clog2(MAX_SIDE+1)-1:0]        i_width,
    input  logic [$clog2(MAX_SIDE+1)-1:0]        i_height,
    output logic                                 o_push,
    output logic                                 o_changed,
    output logic                                 o_last,
    output logic [$clog2(MAX_SIDE)-1:0]          o_x,
    output logic [$clog2(MAX_SIDE)-1:0]          o_y
);
    import fcbb_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int PW = $clog2(MAX_SIDE);

    logic [PW-1:0] r_col, n_col;
    logic [PW-1:0] r_row, n_row;
    logic          row_end;
    logic          frame_end;

    assign o_push    = i_in_valid && !i_q_full;
    assign o_changed = group_sum(i_old_group) != group_sum(i_new_group);
    assign o_x       = r_col;
    assign o_y       = r_row;

    // row ends when the next group would reach or pass the width
    assign row_end   = ((SW+1)'(r_col) + (SW+1)'(GROUP_PIXELS)) >= (SW+1)'(i_width);
    assign frame_end = row_end && (((SW+1)'(r_row) + (SW+1)'(1)) >= (SW+1)'(i_height));
    assign o_last    = frame_end;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + PW'(1);
            end else begin
                n_col = r_col + PW'(GROUP_PIXELS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && frame_end |=> r_col == '0 && r_row == '0)
        else $error("position not cleared after last group");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_push |=> $stable(r_col) && $stable(r_row))
        else $error("position moved without a request");

endmodule

>>> hdl/fcbb_queue.sv
module fcbb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import fcbb_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_pop;

    assign o_full  = r_cnt == CW'(Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) n_cnt = r_cnt + CW'(1);
        else if (!i_push && do_pop) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(Q_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (do_pop) r_rd <= (r_rd == AW'(Q_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(Q_DEPTH))
        else $error("queue count past depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != CW'(Q_DEPTH) && r_cnt != '0 |-> r_wr != r_rd)
        else $error("pointers disagree with count");

endmodule

>>> hdl/fcbb_back.sv
module fcbb_back #(
    parameter int MAX_SIDE = fcbb_pkg::DEF_MAX_SIDE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic                                 i_changed,
    input  logic                                 i_last,
    input  logic [$clog2(MAX_SIDE)-1:0]          i_x,
    input  logic [$clog2(MAX_SIDE)-1:0]          i_y,
    output logic                                 o_pop,
    input  logic [$clog2(MAX_SIDE+1)-1:0]        i_width,
    input  logic [$clog2(MAX_SIDE+1)-1:0]        i_height,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_no_change,
    output logic [fcbb_pkg::POS_OW-1:0]          o_rect_top,
    output logic [fcbb_pkg::POS_OW-1:0]          o_rect_left,
    output logic [fcbb_pkg::SIZE_OW-1:0]         o_rect_width,
    output logic [fcbb_pkg::SIZE_OW-1:0]         o_rect_height
);
    import fcbb_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int PW = $clog2(MAX_SIDE);
    localparam int DW = (SW > SIZE_OW) ? SW : SIZE_OW;

    // running box of the current frame
    logic          r_seen, n_seen;
    logic [PW-1:0] r_top, n_top;
    logic [PW-1:0] r_left, n_left;
    logic [SW-1:0] r_bottom, n_bottom;
    logic [SW-1:0] r_right, n_right;

    // finished box waiting for the margin step
    logic          r_fin_vld;
    logic          r_fin_seen;
    logic [PW-1:0] r_fin_top, r_fin_left;
    logic [SW-1:0] r_fin_bottom, r_fin_right;

    logic          r_out_vld;
    logic          r_no_change;
    logic [POS_OW-1:0]  r_rect_top, r_rect_left;
    logic [SIZE_OW-1:0] r_rect_width, r_rect_height;

    logic          out_free;
    logic          fin_free;
    logic          fin_move;

    logic [SW-1:0]   wm1, hm1;
    logic [SW-1:0]   top_m, left_m, right_m, bottom_m;
    logic [SW:0]     right_p3;
    logic [DW-1:0]   width_d, height_d, top_d, left_d;

    assign out_free = !r_out_vld || !i_out_stall;
    assign fin_move = r_fin_vld && out_free;
    assign fin_free = !r_fin_vld || out_free;
    assign o_pop    = i_q_valid && (!i_last || fin_free);

    // box update on a changed group
    always_comb begin
        n_seen   = r_seen;
        n_top    = r_top;
        n_left   = r_left;
        n_bottom = r_bottom;
        n_right  = r_right;
        if (i_changed) begin
            n_bottom = SW'(i_y) + SW'(1);
            if (!r_seen) begin
                n_seen  = 1'b1;
                n_top   = i_y;
                n_left  = i_x;
                n_right = SW'(i_x) + SW'(1);
            end else if (i_x < r_left) begin
                n_left = i_x;
            end else if (r_right < SW'(i_x)) begin
                n_right = SW'(i_x) + SW'(1);
            end
        end
    end

    // margins around the finished box
    always_comb begin
        wm1      = i_width - SW'(1);
        hm1      = i_height - SW'(1);
        top_m    = (SW'(r_fin_top) >= SW'(3)) ? SW'(r_fin_top) - SW'(3) : '0;
        left_m   = (r_fin_left != '0) ? SW'(r_fin_left) - SW'(1) : '0;
        right_p3 = (SW+1)'(r_fin_right) + (SW+1)'(3);
        if (r_fin_right >= wm1) right_m = r_fin_right;
        else if (right_p3 < (SW+1)'(wm1)) right_m = right_p3[SW-1:0];
        else right_m = wm1;
        bottom_m = (r_fin_bottom < hm1) ? r_fin_bottom + SW'(1) : r_fin_bottom;
        width_d  = DW'(right_m) - DW'(left_m);
        height_d = DW'(bottom_m) - DW'(top_m);
        top_d    = DW'(top_m);
        left_d   = DW'(left_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_top     <= '0;
            r_left    <= '0;
            r_bottom  <= '0;
            r_right   <= '0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_last) begin
                    r_seen   <= 1'b0;
                    r_top    <= '0;
                    r_left   <= '0;
                    r_bottom <= '0;
                    r_right  <= '0;
                end else begin
                    r_seen   <= n_seen;
                    r_top    <= n_top;
                    r_left   <= n_left;
                    r_bottom <= n_bottom;
                    r_right  <= n_right;
                end
            end
            if (o_pop && i_last) r_fin_vld <= 1'b1;
            else if (fin_move) r_fin_vld <= 1'b0;
            if (fin_move) r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_last) begin
            r_fin_seen   <= n_seen;
            r_fin_top    <= n_top;
            r_fin_left   <= n_left;
            r_fin_bottom <= n_bottom;
            r_fin_right  <= n_right;
        end
        if (fin_move) begin
            r_no_change <= !r_fin_seen;
            if (r_fin_seen) begin
                r_rect_top    <= top_d[POS_OW-1:0];
                r_rect_left   <= left_d[POS_OW-1:0];
                r_rect_width  <= width_d[SIZE_OW-1:0];
                r_rect_height <= height_d[SIZE_OW-1:0];
            end else begin
                r_rect_top    <= '0;
                r_rect_left   <= '0;
                r_rect_width  <= '0;
                r_rect_height <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_no_change   = r_no_change;
    assign o_rect_top    = r_rect_top;
    assign o_rect_left   = r_rect_left;
    assign o_rect_width  = r_rect_width;
    assign o_rect_height = r_rect_height;

    a_empty_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> r_top == '0 && r_left == '0 && r_bottom == '0 && r_right == '0)
        else $error("box not clear before first hit");

    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_vld && !out_free |=> r_fin_vld)
        else $error("finished box lost while output busy");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_change |-> o_rect_top == '0 && o_rect_left == '0
            && o_rect_width == '0 && o_rect_height == '0)
        else $error("empty result carries a rectangle");

endmodule

>>> hdl/frame_change_bounding_box.sv
// frame_change_bounding_box
// input channel: i_in_valid / o_in_stall, one request per group of four pixel
//   words, old frame and new frame side by side, in raster order
// output channel: o_out_valid / i_out_stall, one request per frame, sent after
//   the last group of the frame; o_no_change flags a frame with no change
// configuration: i_cfg_we writes frame_width (index 0) or frame_height
//   (index 1); values are clamped to 4..MAX_SIDE and 1..MAX_SIDE on write
// throughput: one group per cycle while o_in_stall is low; the front sums and
//   compares each group in the cycle it is taken, the back updates the box
//   one group per cycle unless held at frame end; a frame's last group moves
//   via queue and finished-box register to the result once the output is free
// a four-entry queue parts front and back; o_in_stall rises only when it is
//   full, which happens while a stalled result holds the back at frame end
// reset (synchronous, active low) clears positions, box, queue and output
//   valid, and loads 1920 x 1080 into the registers
// the result is held unchanged while i_out_stall is high
module frame_change_bounding_box #(
    parameter int MAX_SIDE = fcbb_pkg::DEF_MAX_SIDE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [0:0]                   i_cfg_index,
    input  logic [fcbb_pkg::CFG_DW-1:0]  i_cfg_data,
    // group requests
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_old_pixel_0,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_old_pixel_1,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_old_pixel_2,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_old_pixel_3,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_new_pixel_0,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_new_pixel_1,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_new_pixel_2,
    input  logic [fcbb_pkg::PIX_W-1:0]   i_new_pixel_3,
    // result requests
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_no_change,
    output logic [fcbb_pkg::POS_OW-1:0]  o_rect_top,
    output logic [fcbb_pkg::POS_OW-1:0]  o_rect_left,
    output logic [fcbb_pkg::SIZE_OW-1:0] o_rect_width,
    output logic [fcbb_pkg::SIZE_OW-1:0] o_rect_height
);
    import fcbb_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int PW = $clog2(MAX_SIDE);
    // queue entry: changed flag, last-group flag, x, y
    localparam int QW = 2 + 2 * PW;

    // clamped frame size
    logic [SW-1:0] r_width, r_height;

    t_group        old_group, new_group;

    logic          q_full, q_valid, q_pop, push;
    logic          f_changed, f_last;
    logic [PW-1:0] f_x, f_y;
    logic [QW-1:0] q_wdata, q_rdata;

    logic          b_changed, b_last;
    logic [PW-1:0] b_x, b_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SW'(clamp_side(32'(RST_FRAME_WIDTH), 32'(MIN_FRAME_WIDTH),
                                       32'(MAX_SIDE)));
            r_height <= SW'(clamp_side(32'(RST_FRAME_HEIGHT), 32'(MIN_FRAME_HEIGHT),
                                       32'(MAX_SIDE)));
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH: begin
                    r_width <= SW'(clamp_side(32'(i_cfg_data), 32'(MIN_FRAME_WIDTH),
                                              32'(MAX_SIDE)));
                end
                REG_FRAME_HEIGHT: begin
                    r_height <= SW'(clamp_side(32'(i_cfg_data), 32'(MIN_FRAME_HEIGHT),
                                               32'(MAX_SIDE)));
                end
                default: begin
                end
            endcase
        end
    end

    assign old_group  = {i_old_pixel_3, i_old_pixel_2, i_old_pixel_1, i_old_pixel_0};
    assign new_group  = {i_new_pixel_3, i_new_pixel_2, i_new_pixel_1, i_new_pixel_0};
    assign o_in_stall = q_full;

    // front: position tracking and change test per group
    fcbb_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_old_group (old_group),
        .i_new_group (new_group),
        .i_q_full    (q_full),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_push      (push),
        .o_changed   (f_changed),
        .o_last      (f_last),
        .o_x         (f_x),
        .o_y         (f_y)
    );

    assign q_wdata = {f_changed, f_last, f_x, f_y};

    fcbb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {b_changed, b_last, b_x, b_y} = q_rdata;

    // back: box update, margins and the result register
    fcbb_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_changed     (b_changed),
        .i_last        (b_last),
        .i_x           (b_x),
        .i_y           (b_y),
        .o_pop         (q_pop),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_no_change   (o_no_change),
        .o_rect_top    (o_rect_top),
        .o_rect_left   (o_rect_left),
        .o_rect_width  (o_rect_width),
        .o_rect_height (o_rect_height)
    );

endmodule
